### rtl/upe_pkg.sv
// Shared types and constants for the URL percent encoder.
// No dependencies; upe_front, upe_queue, upe_back and the top level import it.
package upe_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_ESCAPE_SLASH   = 2'd0;
   localparam logic [1:0] CSR_HOST_PORT_MODE = 2'd1;

   localparam logic [7:0] PERCENT_CHAR = 8'h25;
   localparam logic [7:0] SLASH_CHAR   = 8'h2F;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;
   localparam logic [7:0] DEL_CHAR     = 8'h7F;

   typedef struct packed {
      logic escape_slash;
      logic host_port_mode;
   } cfg_type;

   // one classified word waiting for the back end
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
      logic       escape;
   } entry_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_HIGH,
      PH_LOW
   } phase_type;

endpackage

### rtl/upe_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
interface upe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;
   modport source (output valid, in_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface upe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       string_end;
   modport source (output valid, out_byte, last_of_run, string_end, input ready);
   modport sink   (input valid, out_byte, last_of_run, string_end, output ready);
endinterface

### rtl/upe_front.sv
// Front end: accepts request words and decides which bytes need escaping.
// Depends on upe_pkg and upe_req_if.
module upe_front (
   upe_req_if.sink              req_chan,
   input  upe_pkg::cfg_type     cfg,
   input  logic                 push_ready,
   output logic                 push_valid,
   output upe_pkg::entry_type   push_entry
);
   import upe_pkg::*;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_host_keep(input logic [7:0] c);
      return c == 8'h2D || c == 8'h2E || c == 8'h3A || c == 8'h5B || c == 8'h5D;
   endfunction

   function automatic logic is_unsafe(input logic [7:0] c);
      logic r;
      case (c)
         8'h20, 8'h3C, 8'h3E, 8'h22, 8'h25, 8'h7B, 8'h7D, 8'h7C, 8'h5C,
         8'h5E, 8'h60, 8'h3A, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21,
         8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B,
         8'h3D: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   logic [7:0] c;
   logic       esc;

   assign c = req_chan.in_byte;

   always_comb begin
      if (c <= CTRL_MAX || c >= DEL_CHAR) begin
         esc = 1'b1;
      end else if (c == SLASH_CHAR && cfg.escape_slash) begin
         esc = 1'b1;
      end else if (cfg.host_port_mode) begin
         esc = !is_alnum(c) && !is_host_keep(c);
      end else begin
         esc = is_unsafe(c);
      end
   end

   assign req_chan.ready    = push_ready;
   assign push_valid        = req_chan.valid;
   assign push_entry.data   = c;
   assign push_entry.eos    = req_chan.end_of_string;
   assign push_entry.escape = esc;

endmodule

### rtl/upe_queue.sv
// Short FIFO between the classifier and the serializer.
// Depends on upe_pkg for the entry type.
module upe_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  upe_pkg::entry_type  push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output upe_pkg::entry_type  pop_entry
);
   import upe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type        slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/upe_back.sv
// Back end: expands queued entries into one or three response words.
// Depends on upe_pkg and upe_rsp_if.
module upe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  upe_pkg::entry_type  pop_entry,
   output logic                pop,
   upe_rsp_if.source           rsp_chan
);
   import upe_pkg::*;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h37 + {4'd0, v};
   endfunction

   phase_type  phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       send_end_ff, send_end_in;
   logic       advance, take, is_last;

   // output register is free or being drained this cycle
   assign advance = !valid_ff || rsp_chan.ready;
   assign take    = advance && pop_valid;
   assign is_last = !pop_entry.escape || phase_ff == PH_LOW;
   assign pop     = take && is_last;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (phase_ff)
            PH_FIRST: phase_in = pop_entry.escape ? PH_HIGH : PH_FIRST;
            PH_HIGH:  phase_in = PH_LOW;
            PH_LOW:   phase_in = PH_FIRST;
            default:  phase_in = PH_FIRST;
         endcase
      end
   end

   // response word for the current phase
   always_comb begin
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      send_end_in = send_end_ff;
      if (advance) begin
         valid_in = pop_valid;
      end
      if (take) begin
         last_in     = is_last;
         send_end_in = is_last && pop_entry.eos;
         if (!pop_entry.escape) begin
            byte_in = pop_entry.data;
         end else begin
            case (phase_ff)
               PH_FIRST: byte_in = PERCENT_CHAR;
               PH_HIGH:  byte_in = hex_digit(pop_entry.data[7:4]);
               PH_LOW:   byte_in = hex_digit(pop_entry.data[3:0]);
               default:  byte_in = PERCENT_CHAR;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      send_end_ff <= send_end_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.string_end  = send_end_ff;

endmodule

### rtl/url_percent_encoder_unit.sv
// Top level of the URL percent encoder: CSRs, classifier, queue, serializer.
// Depends on upe_pkg, upe_channels, upe_front, upe_queue and upe_back.
//
//   channel   direction  payload                                  handshake
//   req_chan  in         in_byte[7:0], end_of_string              valid/ready
//   rsp_chan  out        out_byte[7:0], last_of_run, string_end   valid/ready
//   csr       in         csr_index[1:0], csr_wdata[0]             csr_we
//
// One response word leaves per cycle while rsp_chan is ready: a plain byte
// gives one word, an escaped byte three: the serializer walks '%', high digit,
// low digit. Request words are taken while the queue has room, so the front
// keeps accepting while the back drains. Synchronous active-high reset empties
// the queue and clears both CSRs. Either side may stall without losing words.
module url_percent_encoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   upe_req_if.sink    req_chan,
   upe_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic       csr_wdata
);
   import upe_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop, pop_valid;
   entry_type push_entry, pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ESCAPE_SLASH:   cfg_in.escape_slash   = csr_wdata;
            CSR_HOST_PORT_MODE: cfg_in.host_port_mode = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   upe_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   upe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   upe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
